// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/frs_pkg.sv =====
`timescale 1ns / 1ps

package frs_pkg;

    localparam int RATE_INTERVALS = 3;
    localparam int HEADER_BYTES   = 14;
    localparam int NUM_LANES      = 4;
    localparam int IDX_W = (RATE_INTERVALS > 1) ? $clog2(RATE_INTERVALS) : 1;
    localparam int PH_W  = $clog2(RATE_INTERVALS + 2);

    localparam logic [2:0] OP_TX_OK  = 3'd0;
    localparam logic [2:0] OP_TX_ERR = 3'd1;
    localparam logic [2:0] OP_RX     = 3'd2;
    localparam logic [2:0] OP_TICK   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // Lane order of the four filtered quantities
    localparam int LANE_TX_FRM = 0;
    localparam int LANE_RX_FRM = 1;
    localparam int LANE_TX_OCT = 2;
    localparam int LANE_RX_OCT = 3;

    typedef logic [31:0] t_word;

    // Division by the interval length: (mag >> pre) * recip >> post.
    // Exact floor for any 32-bit magnitude.
    function automatic logic [31:0] div_recip(input logic [1:0] k);
        logic [31:0] r;
        case (k)
            2'd0:    r = 32'h0000_0001;
            2'd1:    r = 32'hCCCC_CCCD;
            2'd2:    r = 32'h8888_8889;
            default: r = 32'h0000_0001;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] div_pre_shift(input logic [1:0] k);
        return (k == 2'd2) ? 2'd2 : 2'd0;
    endfunction

    function automatic logic [5:0] div_post_shift(input logic [1:0] k);
        return (k == 2'd0) ? 6'd0 : 6'd35;
    endfunction

endpackage

// ===== sv/frame_rate_statistics.sv =====
`timescale 1ns / 1ps
// Frame and byte rate statistics for one network interface.
// Input channel (i_in_valid / o_in_ready): one event per item, i_opcode selects
// tx ok, tx error, rx frame, one-second tick or clear; i_frame_size carries the
// tx payload size (header bytes are added here) or the full rx frame size.
// Output channel (o_out_valid / i_out_ready): one result item per event,
// carrying the wrapping totals and the rate estimates of one filter interval.
// A tick produces one result per interval (1 s, 10 s, 60 s), last marks the
// final one; every other event produces a single result with interval 0.
// A frame, error or clear event passes from the input register to the output
// register; back-to-back events sustain one item per cycle while the receiver
// takes each result. A tick holds the execute stage through its steps: first it
// forms the per-second deltas, then it runs a two-stage divide pipeline
// (reciprocal multiply, then correct and accumulate) shared by all intervals,
// one interval entering per cycle unless the receiver stalls; the second stage
// loads each result into the output register. The next item is accepted on
// the tick's last step. Reset (synchronous, active low) zeroes all totals,
// references and estimates, empties both registers and holds o_in_ready low.
// When the receiver stalls, the result holds in the output register and the
// execute stage waits; one more item is then buffered before o_in_ready drops.
module frame_rate_statistics
    import frs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_opcode,
    input  logic [15:0] i_frame_size,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_tx_frames,
    output logic [31:0] o_rx_frames,
    output logic [31:0] o_tx_octets,
    output logic [31:0] o_rx_octets,
    output logic [31:0] o_send_failures,
    output logic [1:0]  o_interval_index,
    output logic signed [31:0] o_tx_frame_rate_est,
    output logic signed [31:0] o_rx_frame_rate_est,
    output logic signed [31:0] o_tx_byte_rate_est,
    output logic signed [31:0] o_rx_byte_rate_est,
    output logic        o_last
);

    `include "assert_macros.svh"

    // Input register
    logic            r_iv;
    logic [2:0]      r_op;
    logic [15:0]     r_size;
    logic [PH_W-1:0] r_ph;

    // Statistics state
    t_word r_tot   [NUM_LANES];
    t_word r_err;
    t_word r_prev  [NUM_LANES];
    t_word r_est   [NUM_LANES][RATE_INTERVALS];

    // Tick pipeline
    t_word       r_delta [NUM_LANES];
    t_word       r_old   [NUM_LANES];
    logic [63:0] r_prod  [NUM_LANES];
    logic        r_neg   [NUM_LANES];

    // Output register
    logic        r_ov;
    t_word       r_o_tot [NUM_LANES];
    t_word       r_o_err;
    logic [1:0]  r_o_idx;
    t_word       r_o_rate [NUM_LANES];
    logic        r_o_last;

    // Control
    logic            step_en, is_tick, fire, tick_adv, ph_last, in_done;
    logic            mul_en, fin_en, load_out;
    logic [PH_W-1:0] k_mul_w, k_fin_w;
    logic [IDX_W-1:0] k_mul, k_fin;

    // Datapath
    t_word       n_tot   [NUM_LANES];
    t_word       n_err;
    t_word       n_delta [NUM_LANES];
    logic [32:0] diff    [NUM_LANES];
    logic [32:0] mag33   [NUM_LANES];
    t_word       mag_pre [NUM_LANES];
    logic [63:0] n_prod  [NUM_LANES];
    logic [63:0] quo64   [NUM_LANES];
    t_word       est_new [NUM_LANES];
    t_word       d_frm   [NUM_LANES];

    always_comb begin
        step_en  = !r_ov || i_out_ready;
        is_tick  = (r_op == OP_TICK);
        fire     = r_iv && !is_tick && step_en;
        tick_adv = r_iv && is_tick && step_en;
        ph_last  = (r_ph == PH_W'(RATE_INTERVALS + 1));
        in_done  = fire || (tick_adv && ph_last);
        k_mul_w  = r_ph - PH_W'(1);
        k_fin_w  = r_ph - PH_W'(2);
        k_mul    = k_mul_w[IDX_W-1:0];
        k_fin    = k_fin_w[IDX_W-1:0];
        mul_en   = tick_adv && (r_ph != '0) && (r_ph <= PH_W'(RATE_INTERVALS));
        fin_en   = tick_adv && (r_ph >= PH_W'(2));
        load_out = fire || fin_en;
    end

    // Hold off the sender while reset is applied
    assign o_in_ready = i_rst_n && (!r_iv || in_done);

    // Event update of the totals
    always_comb begin
        for (int q = 0; q < NUM_LANES; q++) begin
            n_tot[q] = r_tot[q];
        end
        n_err = r_err;
        case (r_op)
            OP_TX_OK: begin
                n_tot[LANE_TX_FRM] = r_tot[LANE_TX_FRM] + 32'd1;
                n_tot[LANE_TX_OCT] = r_tot[LANE_TX_OCT] + {16'd0, r_size}
                                     + 32'(HEADER_BYTES);
            end
            OP_TX_ERR: begin
                n_err = r_err + 32'd1;
            end
            OP_RX: begin
                n_tot[LANE_RX_FRM] = r_tot[LANE_RX_FRM] + 32'd1;
                n_tot[LANE_RX_OCT] = r_tot[LANE_RX_OCT] + {16'd0, r_size};
            end
            OP_CLEAR: begin
                for (int q = 0; q < NUM_LANES; q++) begin
                    n_tot[q] = '0;
                end
                n_err = '0;
            end
            default: begin
            end
        endcase
    end

    // Tick datapath, one lane per quantity
    always_comb begin
        for (int q = 0; q < NUM_LANES; q++) begin
            // per-second delta; frames scaled by 1000 = 1024 - 16 - 8
            d_frm[q] = r_tot[q] - r_prev[q];
            if (q == LANE_TX_FRM || q == LANE_RX_FRM) begin
                n_delta[q] = (d_frm[q] << 10) - (d_frm[q] << 4) - (d_frm[q] << 3);
            end else begin
                n_delta[q] = d_frm[q];
            end
            // exact signed difference, divided as magnitude to truncate toward zero
            diff[q]    = {r_delta[q][31], r_delta[q]}
                         - {r_est[q][k_mul][31], r_est[q][k_mul]};
            mag33[q]   = diff[q][32] ? (~diff[q] + 33'd1) : diff[q];
            mag_pre[q] = mag33[q][31:0] >> div_pre_shift(2'(k_mul));
            n_prod[q]  = mag_pre[q] * div_recip(2'(k_mul));
            quo64[q]   = r_prod[q] >> div_post_shift(2'(k_fin));
            est_new[q] = r_neg[q] ? (r_old[q] - quo64[q][31:0])
                                  : (r_old[q] + quo64[q][31:0]);
        end
    end

    // Control and state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv  <= 1'b0;
            r_ph  <= '0;
            r_ov  <= 1'b0;
            r_err <= '0;
            for (int q = 0; q < NUM_LANES; q++) begin
                r_tot[q]  <= '0;
                r_prev[q] <= '0;
                for (int k = 0; k < RATE_INTERVALS; k++) begin
                    r_est[q][k] <= '0;
                end
            end
        end else begin
            if (o_in_ready) begin
                r_iv <= i_in_valid;
            end
            if (tick_adv) begin
                r_ph <= ph_last ? '0 : r_ph + PH_W'(1);
            end
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (fire) begin
                r_err <= n_err;
                for (int q = 0; q < NUM_LANES; q++) begin
                    r_tot[q] <= n_tot[q];
                end
                if (r_op == OP_CLEAR) begin
                    for (int q = 0; q < NUM_LANES; q++) begin
                        r_prev[q] <= '0;
                        for (int k = 0; k < RATE_INTERVALS; k++) begin
                            r_est[q][k] <= '0;
                        end
                    end
                end
            end
            // latch the new reference on the tick's first step
            if (tick_adv && r_ph == '0) begin
                for (int q = 0; q < NUM_LANES; q++) begin
                    r_prev[q] <= r_tot[q];
                end
            end
            if (fin_en) begin
                for (int q = 0; q < NUM_LANES; q++) begin
                    r_est[q][k_fin] <= est_new[q];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_op   <= i_opcode;
            r_size <= i_frame_size;
        end
        for (int q = 0; q < NUM_LANES; q++) begin
            if (tick_adv && r_ph == '0) begin
                r_delta[q] <= n_delta[q];
            end
            if (mul_en) begin
                r_old[q]  <= r_est[q][k_mul];
                r_prod[q] <= n_prod[q];
                r_neg[q]  <= diff[q][32];
            end
        end
        if (fire) begin
            r_o_err  <= n_err;
            r_o_idx  <= 2'd0;
            r_o_last <= 1'b1;
            for (int q = 0; q < NUM_LANES; q++) begin
                r_o_tot[q]  <= n_tot[q];
                r_o_rate[q] <= (r_op == OP_CLEAR) ? '0 : r_est[q][0];
            end
        end else if (fin_en) begin
            r_o_err  <= r_err;
            r_o_idx  <= 2'(k_fin);
            r_o_last <= (k_fin == IDX_W'(RATE_INTERVALS - 1));
            for (int q = 0; q < NUM_LANES; q++) begin
                r_o_tot[q]  <= r_tot[q];
                r_o_rate[q] <= est_new[q];
            end
        end
    end

    assign o_out_valid         = r_ov;
    assign o_tx_frames         = r_o_tot[LANE_TX_FRM];
    assign o_rx_frames         = r_o_tot[LANE_RX_FRM];
    assign o_tx_octets         = r_o_tot[LANE_TX_OCT];
    assign o_rx_octets         = r_o_tot[LANE_RX_OCT];
    assign o_send_failures     = r_o_err;
    assign o_interval_index    = r_o_idx;
    assign o_tx_frame_rate_est = r_o_rate[LANE_TX_FRM];
    assign o_rx_frame_rate_est = r_o_rate[LANE_RX_FRM];
    assign o_tx_byte_rate_est  = r_o_rate[LANE_TX_OCT];
    assign o_rx_byte_rate_est  = r_o_rate[LANE_RX_OCT];
    assign o_last              = r_o_last;

    // A tick phase only runs while a tick sits in the execute stage.
    `ASSERT_IMPL(a_phase_owner, i_clk, i_rst_n, r_ph != '0, r_iv && r_op == OP_TICK)
    // The tx octet total and the error count do not move while a tick is being worked through.
    `ASSERT_NEXT(a_tick_totals, i_clk, i_rst_n, r_ph != '0, $stable(r_tot[LANE_TX_OCT]) && $stable(r_err))
    // Taking a non-final tick result brings the next interval's result at once.
    `ASSERT_NEXT(a_tick_order, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_last, o_out_valid && o_interval_index == $past(o_interval_index) + 2'd1)

endmodule
